// ===== hdl/tmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmd_pkg
// Shared constants and types for the tagged message decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tmd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned STAMP_W    = 64;
	localparam int unsigned STAMP_N    = STAMP_W / BYTE_W;
	localparam int unsigned STAMP_CW   = $clog2(STAMP_N);
	localparam int unsigned IN_TDATA_W = 8;
	localparam int unsigned RES_W      = 1 + 2 + 2 + BYTE_W + STAMP_W + BYTE_W;
	localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W  = OUT_TDATA_W - RES_W;

	localparam logic [BYTE_W-1:0] TAG_ERROR   = 8'h65;
	localparam logic [BYTE_W-1:0] TAG_COMMAND = 8'h63;
	localparam logic [BYTE_W-1:0] TAG_METER   = 8'h6D;
	localparam logic [BYTE_W-1:0] SUB_SCHED   = 8'h73;
	localparam logic [BYTE_W-1:0] SUB_STAMP   = 8'h74;
	localparam logic [BYTE_W-1:0] SUB_OBSOL   = 8'h6F;

	localparam logic [1:0] KIND_ERROR   = 2'd0;
	localparam logic [1:0] KIND_COMMAND = 2'd1;
	localparam logic [1:0] KIND_METER   = 2'd2;

	localparam logic [1:0] ERR_NO_SCHED = 2'd0;
	localparam logic [1:0] ERR_NO_STAMP = 2'd1;
	localparam logic [1:0] ERR_OBSOLETE = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0]         meterage;
		logic [STAMP_W-1:0]        time_stamp;
		logic signed [BYTE_W-1:0]  command;
		logic [1:0]                error_type;
		logic [1:0]                kind;
		logic                      ok;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/tmd_parser.sv =====
// ----------------------------------------------------------------------------
// tmd_parser
// Per-byte message state machine; emits one decoded result on the last beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tmd_parser
	import tmd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              beat,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              last,
	output logic                   res_valid,
	output result_t                res
);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_SUBTYPE,
		PH_COMMAND,
		PH_STAMP,
		PH_METER,
		PH_DONE,
		PH_FAIL
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [STAMP_CW-1:0]   count_q, count_d;
	logic [STAMP_W-1:0]    stamp_q, stamp_d;
	logic [BYTE_W-1:0]     value_q, value_d;
	logic [1:0]            kind_q, kind_d;
	logic                  ok;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		stamp_d = stamp_q;
		value_d = value_q;
		kind_d  = kind_q;
		unique case (phase_q)
			PH_TAG: begin
				if (data_byte == TAG_ERROR) begin
					kind_d  = KIND_ERROR;
					phase_d = PH_SUBTYPE;
				end else if (data_byte == TAG_COMMAND) begin
					kind_d  = KIND_COMMAND;
					phase_d = PH_COMMAND;
				end else if (data_byte == TAG_METER) begin
					kind_d  = KIND_METER;
					count_d = '0;
					stamp_d = '0;
					phase_d = PH_STAMP;
				end else begin
					phase_d = PH_FAIL;
				end
			end
			PH_SUBTYPE: begin
				if (data_byte == SUB_SCHED) begin
					value_d = {6'd0, ERR_NO_SCHED};
					phase_d = PH_DONE;
				end else if (data_byte == SUB_STAMP) begin
					value_d = {6'd0, ERR_NO_STAMP};
					phase_d = PH_DONE;
				end else if (data_byte == SUB_OBSOL) begin
					value_d = {6'd0, ERR_OBSOLETE};
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_FAIL;
				end
			end
			PH_COMMAND: begin
				value_d = data_byte;
				phase_d = PH_DONE;
			end
			PH_STAMP: begin
				stamp_d = {stamp_q[STAMP_W-BYTE_W-1:0], data_byte};
				count_d = count_q + 1'b1;
				if (count_q == STAMP_CW'(STAMP_N - 1)) begin
					phase_d = PH_METER;
				end
			end
			PH_METER: begin
				value_d = data_byte;
				phase_d = PH_DONE;
			end
			default: begin
			end
		endcase
	end

	assign ok        = (phase_d == PH_DONE);
	assign res_valid = beat && last;

	always_comb begin
		res.ok         = ok;
		res.kind       = ok ? kind_d : 2'd0;
		res.error_type = (ok && kind_d == KIND_ERROR) ? value_d[1:0] : 2'd0;
		res.command    = (ok && kind_d == KIND_COMMAND) ? value_d : '0;
		res.time_stamp = (ok && kind_d == KIND_METER) ? stamp_d : '0;
		res.meterage   = (ok && kind_d == KIND_METER) ? value_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			count_q <= '0;
			stamp_q <= '0;
			value_q <= '0;
			kind_q  <= '0;
		end else begin
			if (beat) begin
				if (last) begin
					phase_q <= PH_TAG;
					count_q <= '0;
					stamp_q <= '0;
					value_q <= '0;
					kind_q  <= '0;
				end else begin
					phase_q <= phase_d;
					count_q <= count_d;
					stamp_q <= stamp_d;
					value_q <= value_d;
					kind_q  <= kind_d;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tmd_out_buf.sv =====
// ----------------------------------------------------------------------------
// tmd_out_buf
// Output register with a skid stage, so the input side keeps flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module tmd_out_buf
	import tmd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire result_t in_res,
	output logic         in_ready,
	output logic         out_valid,
	output result_t      out_res,
	input  wire logic    out_ready
);

	logic    skid_valid_q;
	result_t skid_q;
	logic    drain;

	assign in_ready = !skid_valid_q;
	assign drain    = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			out_res      <= '0;
			skid_valid_q <= 1'b0;
			skid_q       <= '0;
		end else if (drain) begin
			if (skid_valid_q) begin
				out_res      <= skid_q;
				out_valid    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else if (in_valid) begin
				out_res   <= in_res;
				out_valid <= 1'b1;
			end else begin
				out_valid <= 1'b0;
			end
		end else if (in_valid) begin
			skid_q       <= in_res;
			skid_valid_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tagged_message_decoder.sv =====
// ----------------------------------------------------------------------------
// tagged_message_decoder
// Decodes tagged error, command and meterage messages from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
// Message bytes enter on the s_axis channel, one byte per beat, tag byte
// first, with s_axis_tlast high on the final byte of each message.
// Every byte is absorbed in the beat that carries it, so a new byte can be
// taken on every clock cycle unless the skid register is full. Only the final
// byte produces a result, registered before it appears on the m_axis channel.
// A result beat carries ok, kind, error type, command, timestamp and
// meterage; on failure only ok is low and every other field is zero.
// The output has a result register and a skid register, so a stalled
// receiver holds off the input only once two results are waiting.
// Reset clears the decoder to expect a tag byte and empties both result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_message_decoder
	import tmd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic                   s_axis_tlast,  // last
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [0] ok, [2:1] kind, [4:3] error_type, [12:5] command,
	// [76:13] time_stamp, [84:77] meterage, upper bits zero.
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	logic    beat;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign beat = s_axis_tvalid && s_axis_tready;

	tmd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.data_byte (s_axis_tdata[BYTE_W-1:0]),
		.last      (s_axis_tlast),
		.res_valid (res_valid),
		.res       (res)
	);

	tmd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_res};

endmodule

`default_nettype wire

// ===== hdl/tmd_checker.sv =====
// ----------------------------------------------------------------------------
// tmd_checker
// Port-level checks for the tagged message decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmd_checker
	import tmd_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input wire logic                   s_axis_tlast,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("Input stalled with no result waiting.");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
		else $error("No result after a final beat.");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Result changed while stalled.");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_TDATA_W-1:1] == '0)
		else $error("Failed result carries nonzero fields.");

endmodule

bind tagged_message_decoder tmd_checker u_tmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tagged message decoder.
// Messages go in on the byte stream as directed cases first and then as
// random well-formed, truncated, padded and garbage messages. The input
// side runs in bursts with gaps between them, and the output side stalls in
// changing patterns. A scoreboard decodes every accepted byte on its own and
// compares each result beat, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------

module tb;
	import tmd_pkg::*;

	localparam int unsigned RANDOM_BYTES = 1700;
	localparam int unsigned IDLE_LIMIT   = 1000;
	localparam int unsigned TAIL_CYCLES  = 8;

	typedef logic [7:0] octet_q_t [$];

	typedef enum logic [2:0] {
		AWAIT_TAG,
		AWAIT_SUBTYPE,
		AWAIT_COMMAND,
		AWAIT_STAMP,
		AWAIT_METERAGE,
		COMPLETE,
		ABORTED
	} decode_phase_t;

	class message_scoreboard;
		decode_phase_t phase;
		logic [3:0]    stamp_bytes;
		logic [63:0]   stamp;
		logic [7:0]    value;
		logic [1:0]    kind;
		logic          failed;
		result_t       expected_results [$];
		int unsigned   failures;

		function new();
			failures = 0;
			clear_message();
		endfunction

		function void clear_message();
			phase       = AWAIT_TAG;
			stamp_bytes = '0;
			stamp       = '0;
			value       = '0;
			kind        = KIND_ERROR;
			failed      = 1'b0;
		endfunction

		function void absorb_byte(logic [7:0] b, logic fin);
			result_t r;
			case (phase)
				AWAIT_TAG: begin
					if (b == TAG_ERROR) begin
						kind  = KIND_ERROR;
						phase = AWAIT_SUBTYPE;
					end else if (b == TAG_COMMAND) begin
						kind  = KIND_COMMAND;
						phase = AWAIT_COMMAND;
					end else if (b == TAG_METER) begin
						kind        = KIND_METER;
						stamp_bytes = '0;
						stamp       = '0;
						phase       = AWAIT_STAMP;
					end else begin
						failed = 1'b1;
						phase  = ABORTED;
					end
				end
				AWAIT_SUBTYPE: begin
					if (b == SUB_SCHED) begin
						value = {6'd0, ERR_NO_SCHED};
						phase = COMPLETE;
					end else if (b == SUB_STAMP) begin
						value = {6'd0, ERR_NO_STAMP};
						phase = COMPLETE;
					end else if (b == SUB_OBSOL) begin
						value = {6'd0, ERR_OBSOLETE};
						phase = COMPLETE;
					end else begin
						failed = 1'b1;
						phase  = ABORTED;
					end
				end
				AWAIT_COMMAND: begin
					value = b;
					phase = COMPLETE;
				end
				AWAIT_STAMP: begin
					stamp       = {stamp[55:0], b};
					stamp_bytes = stamp_bytes + 4'd1;
					if (stamp_bytes >= 4'd8)
						phase = AWAIT_METERAGE;
				end
				AWAIT_METERAGE: begin
					value = b;
					phase = COMPLETE;
				end
				default: begin
				end
			endcase
			if (fin) begin
				r = '0;
				if (phase == COMPLETE && !failed) begin
					r.ok   = 1'b1;
					r.kind = kind;
					if (kind == KIND_ERROR) begin
						r.error_type = value[1:0];
					end else if (kind == KIND_COMMAND) begin
						r.command = value;
					end else begin
						r.time_stamp = stamp;
						r.meterage   = value;
					end
				end
				expected_results.push_back(r);
				clear_message();
			end
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] got);
			failures++;
			if (failures <= 10)
				$display("mismatch on %s: expected %h, got %h", what, want, got);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] beat);
			result_t got;
			result_t want;
			got = result_t'(beat[RES_W-1:0]);
			if (expected_results.size() == 0) begin
				flag("unexpected beat", '0, beat[63:0]);
				return;
			end
			want = expected_results.pop_front();
			if (got.ok !== want.ok)
				flag("ok", 64'(want.ok), 64'(got.ok));
			if (got.kind !== want.kind)
				flag("kind", 64'(want.kind), 64'(got.kind));
			if (got.error_type !== want.error_type)
				flag("error_type", 64'(want.error_type), 64'(got.error_type));
			if (got.command !== want.command)
				flag("command", 64'($unsigned(want.command)), 64'($unsigned(got.command)));
			if (got.time_stamp !== want.time_stamp)
				flag("time_stamp", want.time_stamp, got.time_stamp);
			if (got.meterage !== want.meterage)
				flag("meterage", 64'(want.meterage), 64'(got.meterage));
			if (beat[OUT_TDATA_W-1:RES_W] !== '0)
				flag("padding", '0, 64'(beat[OUT_TDATA_W-1:RES_W]));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [7:0] data_byte
	logic                   s_axis_tlast = 1'b0;  // last
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [0] ok, [2:1] kind, [4:3] error_type, [12:5] command,
	// [76:13] time_stamp, [84:77] meterage, upper bits zero.
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	message_scoreboard sb = new();

	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_tick = 0;

	tagged_message_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Input beats are noted before output beats so that both orders of
	// processes within one edge give the same result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.absorb_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(32, 256);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= (stall_tick % 5) < 2;
			default: m_axis_tready <= (stall_tick % 16) == 0;
		endcase
	end

	task automatic send_beat(input logic [7:0] b, input logic fin);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic send_message(input octet_q_t msg);
		foreach (msg[i])
			send_beat(msg[i], i == msg.size() - 1);
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		burst_left = 0;
	endtask

	function automatic octet_q_t random_message(output int unsigned counted);
		octet_q_t    m;
		int unsigned pick;
		int unsigned trail;
		int unsigned cut;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			case ($urandom_range(0, 2))
				0: begin
					m.push_back(TAG_ERROR);
					case ($urandom_range(0, 6))
						0, 1: m.push_back(SUB_SCHED);
						2, 3: m.push_back(SUB_STAMP);
						4, 5: m.push_back(SUB_OBSOL);
						default: m.push_back(8'($urandom_range(0, 255)));
					endcase
				end
				1: begin
					m.push_back(TAG_COMMAND);
					m.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					m.push_back(TAG_METER);
					repeat (9)
						m.push_back(8'($urandom_range(0, 255)));
				end
			endcase
			if ($urandom_range(0, 6) == 0) begin
				cut = $urandom_range(1, m.size() - 1);
				while (m.size() > cut)
					void'(m.pop_back());
			end else if ($urandom_range(0, 3) == 0) begin
				trail = $urandom_range(1, 4);
				repeat (trail)
					m.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			repeat ($urandom_range(1, 6))
				m.push_back(8'($urandom_range(0, 255)));
		end
		counted = m.size();
		return m;
	endfunction

	initial begin
		octet_q_t    msg;
		int unsigned counted;
		int unsigned total;
		int unsigned messages;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_message('{TAG_ERROR, SUB_SCHED});
		send_message('{TAG_ERROR, SUB_STAMP});
		send_message('{TAG_ERROR, SUB_OBSOL});
		send_message('{TAG_ERROR, 8'hFF});
		send_message('{TAG_COMMAND, 8'h80});
		send_message('{TAG_COMMAND, 8'h7F});
		send_message('{TAG_METER, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA,
			8'hFF});
		send_message('{TAG_COMMAND});
		send_message('{8'h00});
		send_message('{TAG_ERROR, SUB_SCHED, 8'h00});
		wait_for_results();

		total    = 0;
		messages = 0;
		while (total < RANDOM_BYTES) begin
			msg = random_message(counted);
			send_message(msg);
			total += counted;
			messages++;
			if (messages % 50 == 0)
				wait_for_results();
		end

		s_axis_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tmd_pkg.sv
hdl/tmd_parser.sv
hdl/tmd_out_buf.sv
hdl/tagged_message_decoder.sv
hdl/tmd_checker.sv
verif/tb.sv
